### src/dclt_pkg.sv
// ----------------------------------------------------------------------------
// dclt_pkg
// Shared types, codes and helpers of the command line tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package dclt_pkg;

   localparam int ByteWidth = 8;
   localparam int PosWidth  = 12;
   localparam int ArgWidth  = 6;
   localparam int BufWidth  = 13;
   localparam int SlotWidth = 7;
   localparam int CsrWidth  = 13;

   localparam logic [BufWidth-1:0]  BufBytesMax   = 13'd4096;
   localparam logic [BufWidth-1:0]  BufBytesReset = 13'd256;
   localparam logic [SlotWidth-1:0] ArgSlotsMax   = 7'd64;
   localparam logic [SlotWidth-1:0] ArgSlotsReset = 7'd32;

   // configuration register indexes
   localparam logic CSR_BUFFER_BYTES = 1'b0;
   localparam logic CSR_ARG_SLOTS    = 1'b1;

   // event codes
   localparam logic [1:0] EV_STORE = 2'd0;
   localparam logic [1:0] EV_ARG   = 2'd1;
   localparam logic [1:0] EV_DONE  = 2'd2;
   localparam logic [1:0] EV_ERR   = 2'd3;

   // characters
   localparam logic [ByteWidth-1:0] CH_NUL    = 8'h00;
   localparam logic [ByteWidth-1:0] CH_QUOTE  = 8'h22;
   localparam logic [ByteWidth-1:0] CH_SLASH  = 8'h2F;
   localparam logic [ByteWidth-1:0] CH_BSLASH = 8'h5C;
   localparam logic [ByteWidth-1:0] CH_DASH   = 8'h2D;

   // event slots of one item, in emission order
   localparam int SLOT_ERR   = 0;
   localparam int SLOT_PRE   = 1;
   localparam int SLOT_BEGIN = 2;
   localparam int SLOT_DASH  = 3;
   localparam int SLOT_MAIN  = 4;
   localparam int SLOT_TERM  = 5;
   localparam int SLOT_DONE  = 6;
   localparam int SlotCount  = 7;

   // queue between front and back
   localparam int QueueDepth = 2;
   localparam int QueueAw    = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int QueueCw    = $clog2(QueueDepth + 1);

   typedef struct packed {
      logic [SlotCount-1:0] mask;
      logic [PosWidth-1:0]  wp;
      logic [ArgWidth-1:0]  at;
      logic [ByteWidth-1:0] main_byte;
   } desc_type;

   function automatic logic is_space(input logic [ByteWidth-1:0] c);
      return c inside {8'd32, [8'd9:8'd13]};
   endfunction

endpackage

`default_nettype wire

### src/dclt_front.sv
// ----------------------------------------------------------------------------
// dclt_front
// Accepts characters, tracks line state and classifies each character into
// a descriptor of the events it causes.
// ----------------------------------------------------------------------------
`default_nettype none

module dclt_front
   import dclt_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_enable,
   input  wire logic                  csr_index,
   input  wire logic [CsrWidth-1:0]   csr_data,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [ByteWidth-1:0]  req_ch,
   input  wire logic [ByteWidth-1:0]  req_next_one,
   input  wire logic [ByteWidth-1:0]  req_next_two,
   input  wire logic                  q_full,
   output logic                       q_push,
   output desc_type                   q_desc
);

   logic [BufWidth-1:0]  buffer_bytes_ff;
   logic [SlotWidth-1:0] arg_slots_ff;
   logic                 inside_arg_ff, inside_arg_in;
   logic                 inside_quotes_ff, inside_quotes_in;
   logic                 line_failed_ff, line_failed_in;
   logic [PosWidth-1:0]  wp_ff, wp_in;
   logic [ArgWidth-1:0]  at_ff, at_in;

   logic [BufWidth-1:0]  bb_eff;
   logic [SlotWidth-1:0] as_eff;
   logic                 ends;
   logic                 err_hit;
   logic                 accept;
   logic [SlotCount-1:0] mask;
   logic [ByteWidth-1:0] main_byte;
   logic [2:0]           n_stores;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign ends      = (req_next_one == CH_NUL);
   assign bb_eff    = (buffer_bytes_ff > BufBytesMax) ? BufBytesMax : buffer_bytes_ff;
   assign as_eff    = (arg_slots_ff > ArgSlotsMax) ? ArgSlotsMax : arg_slots_ff;
   assign err_hit   = (({1'b0, wp_ff} + BufWidth'(4)) >= bb_eff)
                   || (({1'b0, at_ff} + SlotWidth'(1)) >= as_eff);

   always_comb begin
      mask             = '0;
      main_byte        = req_ch;
      inside_arg_in    = inside_arg_ff;
      inside_quotes_in = inside_quotes_ff;
      line_failed_in   = line_failed_ff;
      wp_in            = wp_ff;
      at_in            = at_ff;
      if (line_failed_ff) begin
         if (ends) begin
            line_failed_in = 1'b0;
            inside_arg_in  = 1'b0;
            inside_quotes_in = 1'b0;
            wp_in          = '0;
            at_in          = '0;
         end
      end else if (err_hit) begin
         mask[SLOT_ERR] = 1'b1;
         line_failed_in = 1'b1;
         if (ends) begin
            line_failed_in   = 1'b0;
            inside_arg_in    = 1'b0;
            inside_quotes_in = 1'b0;
            wp_in            = '0;
            at_in            = '0;
         end
      end else begin
         if (inside_quotes_ff) begin
            if (req_ch == CH_QUOTE) begin
               inside_quotes_in = 1'b0;
            end else begin
               mask[SLOT_MAIN] = 1'b1;
            end
         end else if (req_ch == CH_QUOTE) begin
            mask[SLOT_PRE]   = inside_arg_ff;
            mask[SLOT_BEGIN] = 1'b1;
            inside_arg_in    = 1'b1;
            inside_quotes_in = 1'b1;
         end else if (is_space(req_ch)) begin
            mask[SLOT_PRE] = inside_arg_ff;
            inside_arg_in  = 1'b0;
         end else if (req_ch == CH_SLASH) begin
            mask[SLOT_PRE]   = inside_arg_ff;
            mask[SLOT_BEGIN] = 1'b1;
            mask[SLOT_DASH]  = (req_next_one != CH_NUL) && (req_next_two != CH_NUL)
                            && (req_next_two != CH_SLASH) && !is_space(req_next_two);
            mask[SLOT_MAIN]  = 1'b1;
            main_byte        = CH_DASH;
            inside_arg_in    = 1'b1;
         end else begin
            mask[SLOT_BEGIN] = !inside_arg_ff;
            mask[SLOT_MAIN]  = 1'b1;
            main_byte        = (req_ch == CH_BSLASH) ? CH_SLASH : req_ch;
            inside_arg_in    = 1'b1;
         end
         if (ends) begin
            mask[SLOT_TERM]  = inside_arg_in;
            mask[SLOT_DONE]  = 1'b1;
            inside_arg_in    = 1'b0;
            inside_quotes_in = 1'b0;
            wp_in            = '0;
            at_in            = '0;
         end else begin
            wp_in = wp_ff + PosWidth'(n_stores);
            at_in = at_ff + ArgWidth'(mask[SLOT_BEGIN]);
         end
      end
   end

   assign n_stores = 3'(mask[SLOT_PRE]) + 3'(mask[SLOT_DASH]) + 3'(mask[SLOT_MAIN])
                   + 3'(mask[SLOT_TERM]);

   assign q_push           = accept && (mask != '0);
   assign q_desc.mask      = mask;
   assign q_desc.wp        = wp_ff;
   assign q_desc.at        = at_ff;
   assign q_desc.main_byte = main_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_bytes_ff  <= BufBytesReset;
         arg_slots_ff     <= ArgSlotsReset;
         inside_arg_ff    <= 1'b0;
         inside_quotes_ff <= 1'b0;
         line_failed_ff   <= 1'b0;
         wp_ff            <= '0;
         at_ff            <= '0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_BUFFER_BYTES) begin
               buffer_bytes_ff <= csr_data[BufWidth-1:0];
            end else begin
               arg_slots_ff <= csr_data[SlotWidth-1:0];
            end
         end
         if (accept) begin
            inside_arg_ff    <= inside_arg_in;
            inside_quotes_ff <= inside_quotes_in;
            line_failed_ff   <= line_failed_in;
            wp_ff            <= wp_in;
            at_ff            <= at_in;
         end
      end
   end

endmodule

`default_nettype wire

### src/dclt_queue.sv
// ----------------------------------------------------------------------------
// dclt_queue
// Short descriptor queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module dclt_queue
   import dclt_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  desc_type      push_desc,
   output logic          full,
   input  wire logic     pop,
   output logic          valid,
   output desc_type      head
);

   desc_type             mem_ff [QueueDepth];
   logic [QueueAw-1:0]   wr_ptr_ff;
   logic [QueueAw-1:0]   rd_ptr_ff;
   logic [QueueCw-1:0]   count_ff;

   assign full  = (count_ff == QueueCw'(QueueDepth));
   assign valid = (count_ff != '0);
   assign head  = mem_ff[rd_ptr_ff];

   function automatic logic [QueueAw-1:0] wrap_inc(input logic [QueueAw-1:0] p);
      return (p == QueueAw'(QueueDepth - 1)) ? '0 : p + QueueAw'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            mem_ff[wr_ptr_ff] <= push_desc;
            wr_ptr_ff         <= wrap_inc(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= wrap_inc(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + QueueCw'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - QueueCw'(1);
         end
      end
   end

endmodule

`default_nettype wire

### src/dclt_back.sv
// ----------------------------------------------------------------------------
// dclt_back
// Expands each descriptor into its events, one beat per cycle while rsp_ready
// allows, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dclt_back
   import dclt_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  q_valid,
   input  desc_type                   q_head,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [1:0]                 rsp_event_res,
   output logic [ByteWidth-1:0]       rsp_out_byte,
   output logic [PosWidth-1:0]        rsp_position,
   output logic [ArgWidth-1:0]        rsp_arg_number,
   output logic                       rsp_last
);

   logic [SlotCount-1:0] mask_ff;
   logic [ByteWidth-1:0] main_byte_ff;
   logic [PosWidth-1:0]  wp_ff;
   logic [ArgWidth-1:0]  at_ff;
   logic                 rsp_valid_ff;
   logic [1:0]           rsp_event_res_ff, rsp_event_res_in;
   logic [ByteWidth-1:0] rsp_out_byte_ff, rsp_out_byte_in;
   logic [PosWidth-1:0]  rsp_position_ff;
   logic [ArgWidth-1:0]  rsp_arg_number_ff;
   logic                 rsp_last_ff;

   logic                 advance;
   logic                 have;
   logic                 emit;
   logic                 load;
   logic [SlotCount-1:0] sel;
   logic [SlotCount-1:0] rest;
   logic                 is_store;

   assign advance = !rsp_valid_ff || rsp_ready;
   assign have    = (mask_ff != '0);
   assign sel     = mask_ff & (~mask_ff + SlotCount'(1));
   assign rest    = mask_ff & ~sel;
   assign emit    = advance && have;
   assign load    = q_valid && (!have || (emit && (rest == '0)));
   assign q_pop   = load;
   assign is_store = sel[SLOT_PRE] || sel[SLOT_DASH] || sel[SLOT_MAIN] || sel[SLOT_TERM];

   always_comb begin
      rsp_event_res_in = EV_STORE;
      rsp_out_byte_in  = CH_NUL;
      if (sel[SLOT_ERR]) begin
         rsp_event_res_in = EV_ERR;
      end else if (sel[SLOT_BEGIN]) begin
         rsp_event_res_in = EV_ARG;
      end else if (sel[SLOT_DONE]) begin
         rsp_event_res_in = EV_DONE;
      end else if (sel[SLOT_DASH]) begin
         rsp_out_byte_in = CH_DASH;
      end else if (sel[SLOT_MAIN]) begin
         rsp_out_byte_in = main_byte_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit) begin
            rsp_valid_ff      <= 1'b1;
            rsp_event_res_ff  <= rsp_event_res_in;
            rsp_out_byte_ff   <= rsp_out_byte_in;
            rsp_position_ff   <= wp_ff;
            rsp_arg_number_ff <= at_ff;
            rsp_last_ff       <= (rest == '0);
         end else if (advance) begin
            rsp_valid_ff <= 1'b0;
         end
         if (load) begin
            mask_ff      <= q_head.mask;
            main_byte_ff <= q_head.main_byte;
            wp_ff        <= q_head.wp;
            at_ff        <= q_head.at;
         end else if (emit) begin
            mask_ff <= rest;
            if (is_store) begin
               wp_ff <= wp_ff + PosWidth'(1);
            end
            if (sel[SLOT_BEGIN]) begin
               at_ff <= at_ff + ArgWidth'(1);
            end
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_res  = rsp_event_res_ff;
   assign rsp_out_byte   = rsp_out_byte_ff;
   assign rsp_position   = rsp_position_ff;
   assign rsp_arg_number = rsp_arg_number_ff;
   assign rsp_last       = rsp_last_ff;

`ifndef SYNTH
   a_err_alone: assert property (@(posedge clock) disable iff (reset)
      mask_ff[SLOT_ERR] |-> (mask_ff == SlotCount'(1 << SLOT_ERR)))
      else $error("error slot shares a descriptor with other events");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_event_res_ff == EV_DONE)) |-> rsp_last_ff)
      else $error("line done beat not marked last");

   a_err_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_event_res_ff == EV_ERR)) |-> rsp_last_ff)
      else $error("error beat not marked last");

   a_store_byte_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_event_res_ff != EV_STORE)) |-> (rsp_out_byte_ff == CH_NUL))
      else $error("non-store beat carries a byte");
`endif

endmodule

`default_nettype wire

### src/dos_command_line_tokenizer.sv
// ----------------------------------------------------------------------------
// dos_command_line_tokenizer
// Command line tokenizer: splits a character stream into argument events.
// ----------------------------------------------------------------------------
// The block takes one character per req beat, with the next two characters
// as lookahead, and returns store-byte, argument-begin, line-done and error
// events on the rsp channel, one beat per cycle while rsp_ready allows, the
// final beat of each character marked by rsp_last. A character is accepted
// while the queue has room. One that causes k events yields k beats on the
// result port; one that causes none pushes no descriptor. The sustained
// rate is therefore set by the single event port, zero to five events per
// character. The front and the back are separated by a two-entry descriptor
// queue, and the result port is registered. Write csr registers only while
// the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module dos_command_line_tokenizer
   import dclt_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_enable,
   input  wire logic                  csr_index,
   input  wire logic [CsrWidth-1:0]   csr_data,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [ByteWidth-1:0]  req_ch,
   input  wire logic [ByteWidth-1:0]  req_next_one,
   input  wire logic [ByteWidth-1:0]  req_next_two,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [1:0]                 rsp_event_res,
   output logic [ByteWidth-1:0]       rsp_out_byte,
   output logic [PosWidth-1:0]        rsp_position,
   output logic [ArgWidth-1:0]        rsp_arg_number,
   output logic                       rsp_last
);

   logic     q_full;
   logic     q_push;
   logic     q_pop;
   logic     q_valid;
   desc_type q_desc;
   desc_type q_head;

   dclt_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_ch           (req_ch),
      .req_next_one     (req_next_one),
      .req_next_two     (req_next_two),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_desc           (q_desc)
   );

   dclt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (q_desc),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head      (q_head)
   );

   dclt_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_event_res  (rsp_event_res),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_position   (rsp_position),
      .rsp_arg_number (rsp_arg_number),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire
